// ----- sv/delta_length_prefix_bit_packer_defines.svh -----
// Assertion macros used by the packer back end.
`ifndef DELTA_LENGTH_PREFIX_BIT_PACKER_DEFINES_SVH
`define DELTA_LENGTH_PREFIX_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst is high.
`define DLPBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dlpbp assertion failed");

// Next-cycle implication, checked on clk, off while rst is high.
`define DLPBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dlpbp assertion failed");

`endif

// ----- sv/dlpbp_pkg.sv -----
// Types and constants of the delta length-prefix bit packer.
`default_nettype none
package dlpbp_pkg;

  localparam int VALUE_BITS       = 63;
  localparam int WIDTH_FIELD_BITS = 6;
  localparam int CODE_BITS        = WIDTH_FIELD_BITS + VALUE_BITS;
  localparam int PEND_BITS        = 7;
  localparam int BUF_BITS         = CODE_BITS + PEND_BITS;
  localparam int TOT_BITS         = $clog2(BUF_BITS + 1);
  localparam int MAX_RESULTS      = BUF_BITS / 8 + 1;
  localparam int CNT_BITS         = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_BITS        = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  end_of_block;
  } sample_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       block_flush;
  } code_t;

  // width field followed by the significant difference bits, left aligned
  typedef struct packed {
    logic [CODE_BITS-1:0]        bits;
    logic [WIDTH_FIELD_BITS-1:0] width;
    logic                        eob;
  } job_t;

endpackage
`default_nettype wire

// ----- sv/dlpbp_front.sv -----
// Front end: delta against previous value, bit width, left alignment.
`default_nettype none
module dlpbp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire dlpbp_pkg::sample_t sample,
  output logic                   job_valid,
  input  wire logic              job_ready,
  output dlpbp_pkg::job_t        job
);
  import dlpbp_pkg::*;

  localparam int NG = (VALUE_BITS + 7) / 8;

  // leading-one search in byte groups
  function automatic logic [WIDTH_FIELD_BITS-1:0] bit_width(input logic [VALUE_BITS-1:0] x);
    logic [NG*8-1:0]             xp;
    logic [WIDTH_FIELD_BITS-1:0] w;
    logic [3:0]                  lw;
    xp = (NG*8)'(x);
    w  = '0;
    for (int g = 0; g < NG; g++) begin
      lw = '0;
      for (int b = 0; b < 8; b++) begin
        if (xp[g*8+b]) lw = 4'(b + 1);
      end
      if (lw != 4'd0) w = WIDTH_FIELD_BITS'(g*8) + WIDTH_FIELD_BITS'(lw);
    end
    return w;
  endfunction

  logic [VALUE_BITS-1:0]       prev;
  logic                        s1_valid;
  logic [VALUE_BITS-1:0]       s1_diff;
  logic                        s1_eob;
  logic                        s2_valid;
  logic [VALUE_BITS-1:0]       s2_diff;
  logic [WIDTH_FIELD_BITS-1:0] s2_width;
  logic                        s2_eob;
  logic                        s1_adv;
  logic                        s2_adv;
  logic                        take;
  logic [WIDTH_FIELD_BITS-1:0] shamt;

  always_comb begin
    s2_adv       = s2_valid && job_ready;
    s1_adv       = s1_valid && (!s2_valid || s2_adv);
    sample_ready = !s1_valid || s1_adv;
    take         = sample_valid && sample_ready;
    shamt        = WIDTH_FIELD_BITS'(VALUE_BITS) - s2_width;
    job_valid    = s2_valid;
    job.bits     = {s2_width, s2_diff << shamt};
    job.width    = s2_width;
    job.eob      = s2_eob;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev     <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (take) begin
        prev <= sample.end_of_block ? '0 : sample.value;
      end
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_diff <= sample.value - prev;
      s1_eob  <= sample.end_of_block;
    end
    if (s1_adv) begin
      s2_diff  <= s1_diff;
      s2_width <= bit_width(s1_diff);
      s2_eob   <= s1_eob;
    end
  end

endmodule
`default_nettype wire

// ----- sv/dlpbp_queue.sv -----
// Short job queue between front and back end.
`default_nettype none
module dlpbp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire dlpbp_pkg::job_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output dlpbp_pkg::job_t     pop_data
);
  import dlpbp_pkg::*;

  job_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   fill;
  logic                 push;
  logic                 pop;

  always_comb begin
    push_ready = fill != (QPTR_BITS+1)'(QUEUE_DEPTH);
    pop_valid  = fill != '0;
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
    pop_data   = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

// ----- sv/dlpbp_back.sv -----
// Back end: merges a job with pending bits and emits bytes one per cycle while code_ready allows.
`default_nettype none
`include "delta_length_prefix_bit_packer_defines.svh"
module dlpbp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire dlpbp_pkg::job_t job,
  output logic                code_valid,
  input  wire logic           code_ready,
  output dlpbp_pkg::code_t    code
);
  import dlpbp_pkg::*;

  logic [BUF_BITS-1:0]  buffer;
  logic [CNT_BITS-1:0]  cnt;
  logic                 fl;
  logic [PEND_BITS-1:0] pend_left;
  logic [2:0]           pc;
  code_t                code_q;
  logic                 valid_q;

  logic                 slot_free;
  logic                 emit;
  logic                 pop;
  logic [BUF_BITS-1:0]  merged;
  logic [BUF_BITS-1:0]  leftover;
  logic [TOT_BITS-1:0]  total;
  logic [CNT_BITS-1:0]  nb;
  logic                 fl_new;

  always_comb begin
    slot_free = !valid_q || code_ready;
    emit      = (cnt != '0) && slot_free;
    pop       = job_valid && ((cnt == '0) || ((cnt == CNT_BITS'(1)) && emit));
    job_ready = pop;
    merged    = {pend_left, {CODE_BITS{1'b0}}} | ({job.bits, {PEND_BITS{1'b0}}} >> pc);
    total     = TOT_BITS'(pc) + TOT_BITS'(WIDTH_FIELD_BITS) + TOT_BITS'(job.width);
    nb        = CNT_BITS'(total >> 3);
    fl_new    = job.eob && (total[2:0] != 3'd0);
    // bits left over once all full bytes of this job are out
    leftover  = merged << {nb, 3'b000};
    code_valid = valid_q;
    code       = code_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pend_left <= '0;
      pc        <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (pop) begin
        cnt       <= nb + CNT_BITS'(fl_new);
        pend_left <= job.eob ? '0 : leftover[BUF_BITS-1 -: PEND_BITS];
        pc        <= job.eob ? 3'd0 : total[2:0];
      end else if (emit) begin
        cnt <= cnt - 1'b1;
      end
      if (emit) begin
        valid_q <= 1'b1;
      end else if (code_ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_q.out_byte    <= buffer[BUF_BITS-1 -: 8];
      code_q.last_of_run <= cnt == CNT_BITS'(1);
      code_q.block_flush <= (cnt == CNT_BITS'(1)) && fl;
    end
    if (pop) begin
      buffer <= merged;
      fl     <= fl_new;
    end else if (emit) begin
      buffer <= buffer << 8;
    end
  end

  `DLPBP_ASSERT_NOW(a_pend_clean, 1'b1, (pend_left & (7'h7F >> pc)) == '0)
  `DLPBP_ASSERT_NOW(a_flush_is_last, valid_q && code_q.block_flush, code_q.last_of_run)
  `DLPBP_ASSERT_NEXT(a_eob_clears, pop && job.eob, pc == 3'd0 && pend_left == '0)

endmodule
`default_nettype wire

// ----- sv/delta_length_prefix_bit_packer.sv -----
// Each item yields 0 to 10 bytes; a new job is taken only as the last byte of the current one goes out.
// The byte port moves one byte a cycle while code_ready allows.
// A four-deep job queue lets the delta front end run ahead of the byte packer.
// Reset (rst, synchronous): clears previous value, pending bits, pipeline and queue.
`default_nettype none
module delta_length_prefix_bit_packer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire dlpbp_pkg::sample_t sample,
  output logic                   code_valid,
  input  wire logic              code_ready,
  output dlpbp_pkg::code_t       code
);
  import dlpbp_pkg::*;

  logic fj_valid;
  logic fj_ready;
  job_t fj;
  logic bj_valid;
  logic bj_ready;
  job_t bj;

  dlpbp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .job_valid    (fj_valid),
    .job_ready    (fj_ready),
    .job          (fj)
  );

  dlpbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_data  (fj),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_data   (bj)
  );

  dlpbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (bj_valid),
    .job_ready  (bj_ready),
    .job        (bj),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code       (code)
  );

endmodule
`default_nettype wire

// ----- tb/dlpbp_checker.sv -----
// Watches both channels, predicts the packed code bytes and compares them.
`timescale 1ns / 1ps
module dlpbp_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  input  logic               sample_ready,
  input  dlpbp_pkg::sample_t sample,
  input  logic               code_valid,
  input  logic               code_ready,
  input  dlpbp_pkg::code_t   code,
  output int                 fail_count,
  output int                 outstanding
);
  import dlpbp_pkg::*;

  logic [VALUE_BITS-1:0] prev_value;
  logic [6:0]            acc_bits;
  logic [2:0]            acc_count;
  code_t                 expected_codes[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic shift_in(input logic b, inout int n);
    code_t c;
    if (acc_count == 3'd7) begin
      c.out_byte    = {acc_bits, b};
      c.last_of_run = 1'b0;
      c.block_flush = 1'b0;
      expected_codes.push_back(c);
      acc_bits  = '0;
      acc_count = '0;
      n++;
    end else begin
      acc_bits  = {acc_bits[5:0], b};
      acc_count = acc_count + 3'd1;
    end
  endtask

  // width field, then the significant bits of the difference, MSB first
  task automatic encode_sample(input sample_t s);
    logic [VALUE_BITS-1:0] diff;
    logic [7:0]            pad;
    int                    w;
    int                    n;
    code_t                 c;
    diff = s.value - prev_value;
    w = 0;
    for (int i = 0; i < VALUE_BITS; i++)
      if (diff[i]) w = i + 1;
    n = 0;
    for (int i = WIDTH_FIELD_BITS - 1; i >= 0; i--) shift_in(w[i], n);
    for (int i = w - 1; i >= 0; i--) shift_in(diff[i], n);
    prev_value = s.value;
    if (s.end_of_block) begin
      if (acc_count != 0) begin
        pad           = {1'b0, acc_bits};
        c.out_byte    = pad << (8 - acc_count);
        c.last_of_run = 1'b0;
        c.block_flush = 1'b1;
        expected_codes.push_back(c);
        n++;
      end
      acc_bits   = '0;
      acc_count  = '0;
      prev_value = '0;
    end
    if (n > 0) expected_codes[expected_codes.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic check_code(input code_t got);
    code_t exp_c;
    if (expected_codes.size() == 0) begin
      $error("unexpected code item: out_byte %02h", got.out_byte);
      fail_count++;
    end else begin
      exp_c = expected_codes.pop_front();
      if (got.out_byte !== exp_c.out_byte) begin
        $error("out_byte: expected %02h, got %02h", exp_c.out_byte, got.out_byte);
        fail_count++;
      end
      if (got.last_of_run !== exp_c.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", exp_c.last_of_run, got.last_of_run);
        fail_count++;
      end
      if (got.block_flush !== exp_c.block_flush) begin
        $error("block_flush: expected %0b, got %0b", exp_c.block_flush, got.block_flush);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      prev_value = '0;
      acc_bits   = '0;
      acc_count  = '0;
      expected_codes.delete();
    end else begin
      if (sample_valid && sample_ready) encode_sample(sample);
      if (code_valid && code_ready) check_code(code);
    end
    outstanding = expected_codes.size();
  end

endmodule

// ----- tb/tb_delta_length_prefix_bit_packer.sv -----
// Stimulus and verdict for the delta length-prefix bit packer.
`timescale 1ns / 1ps
module tb_delta_length_prefix_bit_packer;
  import dlpbp_pkg::*;

  localparam logic [VALUE_BITS-1:0] ALL_ONES = {VALUE_BITS{1'b1}};

  logic    clk;
  logic    rst;
  logic    sample_valid;
  logic    sample_ready;
  sample_t sample;
  logic    code_valid;
  logic    code_ready;
  code_t   code;
  int      fail_count;
  int      outstanding;

  bit      no_gaps;
  bit      rx_hold;
  bit      rx_held;

  delta_length_prefix_bit_packer uut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .code_valid  (code_valid),
    .code_ready  (code_ready),
    .code        (code)
  );

  dlpbp_checker chk (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .code_valid  (code_valid),
    .code_ready  (code_ready),
    .code        (code),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  task automatic send_sample(input logic [VALUE_BITS-1:0] v, input logic eob);
    int gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= '{value: v, end_of_block: eob};
    @(negedge clk);
    while (!sample_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    // items with no bytes may still be in flight
    repeat (20) @(posedge clk);
  endtask

  // well-formed blocks of random length with a mix of delta shapes
  task automatic send_blocks(input int count);
    int                    sent;
    int                    len;
    int                    k;
    logic [63:0]           r;
    logic [VALUE_BITS-1:0] last_v;
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] mask;
    sent = 0;
    while (sent < count) begin
      len    = $urandom_range(1, 12);
      last_v = '0;
      for (int j = 0; j < len && sent < count; j++) begin
        r = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            k    = $urandom_range(0, 12);
            mask = (k == 0) ? '0 : (ALL_ONES >> (VALUE_BITS - k));
            v    = last_v + (r[VALUE_BITS-1:0] & mask);
          end
          4: v = last_v;
          5: begin
            k    = $urandom_range(0, VALUE_BITS);
            mask = (k == 0) ? '0 : (ALL_ONES >> (VALUE_BITS - k));
            v    = last_v + (r[VALUE_BITS-1:0] & mask);
          end
          6: v = last_v - VALUE_BITS'($urandom_range(1, 300));
          7: v = r[VALUE_BITS-1:0];
          8: v = ALL_ONES;
          default: v = '0;
        endcase
        send_sample(v, (j == len - 1) || (sent == count - 1));
        last_v = v;
        sent++;
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    rx_held = 1'b0;
    @(negedge rst);
    forever begin
      if (rx_hold && !rx_held) begin
        code_ready <= 1'b0;
        repeat (400) @(posedge clk);
        rx_held = 1'b1;
      end else begin
        gap = ($urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
          code_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      code_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    code_ready   = 1'b0;
    no_gaps      = 1'b0;
    rx_hold      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero difference with no completed byte, then the widest difference
    send_sample('0, 1'b0);
    send_sample(ALL_ONES, 1'b0);
    // decreasing value wraps to a difference of one
    send_sample('0, 1'b0);
    send_sample(VALUE_BITS'(5), 1'b1);
    // end of block flushing a lone width field
    send_sample('0, 1'b1);
    // four zero differences fill three bytes exactly: no flush
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b1);
    // seven bits pending, then a 69-bit code and a flush: ten bytes
    send_sample(VALUE_BITS'(1), 1'b0);
    send_sample('0, 1'b1);
    send_sample(ALL_ONES, 1'b1);
    send_sample(63'h5555_5555_5555_5555, 1'b0);
    send_sample(63'h2AAA_AAAA_AAAA_AAAA, 1'b1);
    send_sample(VALUE_BITS'(42), 1'b0);
    send_sample(VALUE_BITS'(42), 1'b1);
    send_sample(VALUE_BITS'(1), 1'b1);
    wait_drained();

    send_blocks(120);

    // receiver stalls while items keep coming back to back
    rx_hold = 1'b1;
    no_gaps = 1'b1;
    send_blocks(40);
    no_gaps = 1'b0;
    wait_drained();

    send_blocks(143);
    wait_drained();

    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
